// ===== src/address_mapping_table_macros.svh =====
// Assertion macros for the address mapping table.
`ifndef ADDRESS_MAPPING_TABLE_MACROS_SVH
`define ADDRESS_MAPPING_TABLE_MACROS_SVH
`ifndef SYNTHESIS
// Check that pre implies post in the same cycle.
`define AMT_ASSERT_NOW(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);
// Check that pre implies post in the next cycle.
`define AMT_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`else
`define AMT_ASSERT_NOW(label, clk, rst_n, pre, post, msg)
`define AMT_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== src/amt_pkg.sv =====
// Shared types and constants of the address mapping table.
`timescale 1ns / 1ps
`default_nettype none
package amt_pkg;
  localparam int ENTRIES_DEF = 8;
  localparam int KEY_W       = 16;
  localparam int IP_W        = 32;
  localparam int PORT_W      = 16;
  localparam int SLOT_W      = 3;

  typedef enum logic [1:0] {
    FUNC_RECORD = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_GET    = 2'd3
  } func_e_t;

  // Request broadcast to every cell while it travels the chain.
  typedef struct packed {
    func_e_t             func;
    logic [KEY_W-1:0]    key;
    logic [IP_W-1:0]     ip;
    logic [PORT_W-1:0]   port;
  } req_t;

  // Token handed from cell to cell.
  typedef struct packed {
    logic                valid;
    logic                done;
    logic [IP_W-1:0]     ip;
    logic [PORT_W-1:0]   port;
  } tok_t;
endpackage
`default_nettype wire

// ===== src/address_mapping_table.sv =====
// Top level of the address mapping table: request control and cell chain.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one request: an operation code
//   (record, remove, clear all, get), a 16-bit key, and the address and port
//   to store on record. Result channel (out_valid/out_ready) returns one
//   result per request: found flag, slot index, and address/port on get.
//   Each request travels a row of ENTRIES cells, one cell per cycle; the
//   first cell that matches (on record: or is free) acts and marks the
//   token done; a clear empties every cell. A record that finds no slot
//   overwrites the slot after the last recorded one when the token leaves
//   the chain. A request passes the start register, the cells, the result
//   register and the output register; one request is in flight at a time,
//   and in_ready goes high again once its result reaches the output register.
//   If the receiver stalls, the new result holds in the result register and
//   in_ready stays low until the output register is free.
//   Reset (rst_n low, synchronous) frees every slot, zeroes all stored
//   addresses and ports and the last recorded slot, and drops any request.
`timescale 1ns / 1ps
`default_nettype none
`include "address_mapping_table_macros.svh"
module address_mapping_table #(
  parameter int ENTRIES = amt_pkg::ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_func,
  input  logic [amt_pkg::KEY_W-1:0]   in_node_key,
  input  logic [amt_pkg::IP_W-1:0]    in_ip_value,
  input  logic [amt_pkg::PORT_W-1:0]  in_port_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_found,
  output logic [amt_pkg::SLOT_W-1:0]  out_slot,
  output logic [amt_pkg::IP_W-1:0]    out_ip_out,
  output logic [amt_pkg::PORT_W-1:0]  out_port_out
);
  import amt_pkg::*;

  localparam int IW = $clog2(ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_e_t;

  state_e_t          state_r, state_nxt;
  req_t              req_r;
  logic              start_r;
  logic [IW-1:0]     last_r, last_nxt;
  logic              res_found_r;
  logic [SLOT_W-1:0] res_slot_r;
  logic [IP_W-1:0]   res_ip_r;
  logic [PORT_W-1:0] res_port_r;
  logic              out_valid_r;
  logic              out_found_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [IP_W-1:0]   out_ip_r;
  logic [PORT_W-1:0] out_port_r;

  tok_t              tok   [0:ENTRIES];
  logic [IW-1:0]     slot_c[0:ENTRIES];
  logic [ENTRIES-1:0] fb_sel;
  logic [ENTRIES-1:0] tok_busy;
  tok_t              chain_out;
  logic              in_acc, exit_tok, is_rec, fb_we, out_free;
  logic [IW-1:0]     fb_slot, rec_slot;

  assign in_acc    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign chain_out = tok[ENTRIES];
  assign exit_tok  = chain_out.valid;
  assign is_rec    = (req_r.func == FUNC_RECORD);
  assign out_free  = !out_valid_r || out_ready;

  // Slot after the last recorded one, with wrap.
  assign fb_slot  = (last_r == IW'(ENTRIES - 1)) ? '0 : last_r + IW'(1);
  assign fb_we    = exit_tok && is_rec && !chain_out.done;
  assign rec_slot = chain_out.done ? slot_c[ENTRIES] : fb_slot;

  // Inject the token into the first cell the cycle after acceptance.
  assign tok[0]    = '{valid: start_r, done: 1'b0, ip: '0, port: '0};
  assign slot_c[0] = '0;

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      assign fb_sel[g]   = fb_we && (fb_slot == IW'(g));
      assign tok_busy[g] = tok[g+1].valid;
      amt_cell #(
        .ENTRIES (ENTRIES),
        .IDX     (g)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_r),
        .tok_in   (tok[g]),
        .slot_in  (slot_c[g]),
        .fb_we    (fb_sel[g]),
        .tok_out  (tok[g+1]),
        .slot_out (slot_c[g+1])
      );
    end
  endgenerate

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_SCAN;
      S_SCAN:  if (exit_tok) state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Advance the last recorded slot on every record.
  always_comb begin
    last_nxt = last_r;
    if (exit_tok && is_rec) last_nxt = rec_slot;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= in_acc;
      last_r  <= last_nxt;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: request, held result and output.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r.func <= func_e_t'(in_func);
      req_r.key  <= in_node_key;
      req_r.ip   <= in_ip_value;
      req_r.port <= in_port_value;
    end
    if (exit_tok) begin
      res_found_r <= chain_out.done || is_rec;
      if (is_rec) begin
        res_slot_r <= SLOT_W'(rec_slot);
      end else if (chain_out.done) begin
        res_slot_r <= SLOT_W'(slot_c[ENTRIES]);
      end else begin
        res_slot_r <= '0;
      end
      res_ip_r   <= chain_out.ip;
      res_port_r <= chain_out.port;
    end
    if (state_r == S_DONE && out_free) begin
      out_found_r <= res_found_r;
      out_slot_r  <= res_slot_r;
      out_ip_r    <= res_ip_r;
      out_port_r  <= res_port_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_slot     = out_slot_r;
  assign out_ip_out   = out_ip_r;
  assign out_port_out = out_port_r;

  // At most one token travels the chain.
  `AMT_ASSERT_NOW(a_one_token, clk, rst_n, 1'b1, $onehot0(tok_busy), "more than one token in chain")
  // A token leaves the chain only while a request is scanning.
  `AMT_ASSERT_NOW(a_exit_scan, clk, rst_n, exit_tok, state_r == S_SCAN, "token exit outside scan")
  // A held result moves to the output once the output is free.
  `AMT_ASSERT_NEXT(a_done_out, clk, rst_n, state_r == S_DONE && out_free, out_valid_r, "result not delivered")
endmodule
`default_nettype wire

// ===== src/amt_cell.sv =====
// One slot of the table: key, address and port, plus the token stage.
`timescale 1ns / 1ps
`default_nettype none
module amt_cell #(
  parameter int ENTRIES = amt_pkg::ENTRIES_DEF,
  parameter int IDX     = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  amt_pkg::req_t                req,
  input  amt_pkg::tok_t                tok_in,
  input  logic [$clog2(ENTRIES)-1:0]   slot_in,
  input  logic                         fb_we,
  output amt_pkg::tok_t                tok_out,
  output logic [$clog2(ENTRIES)-1:0]   slot_out
);
  import amt_pkg::*;

  localparam int IW = $clog2(ENTRIES);

  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [IP_W-1:0]   ip_r, ip_nxt;
  logic [PORT_W-1:0] port_r, port_nxt;
  tok_t              tok_r, tok_nxt;
  logic [IW-1:0]     slot_r, slot_nxt;
  logic              match, free, hit;

  assign match = (key_r == req.key);
  assign free  = (key_r == '0);

  always_comb begin
    hit = 1'b0;
    if (tok_in.valid && !tok_in.done) begin
      case (req.func) inside
        FUNC_RECORD:           hit = match || free;
        FUNC_REMOVE, FUNC_GET: hit = match;
        default:               hit = 1'b0;
      endcase
    end
  end

  always_comb begin
    key_nxt  = key_r;
    ip_nxt   = ip_r;
    port_nxt = port_r;
    if (fb_we || (hit && req.func == FUNC_RECORD)) begin
      key_nxt  = req.key;
      ip_nxt   = req.ip;
      port_nxt = req.port;
    end else if (hit && req.func == FUNC_REMOVE) begin
      key_nxt = '0;
    end else if (tok_in.valid && req.func == FUNC_CLEAR) begin
      key_nxt = '0;
    end
  end

  always_comb begin
    tok_nxt       = tok_in;
    tok_nxt.done  = tok_in.done || hit;
    slot_nxt      = hit ? IW'(IDX) : slot_in;
    if (hit && req.func == FUNC_GET) begin
      tok_nxt.ip   = ip_r;
      tok_nxt.port = port_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r       <= '0;
      ip_r        <= '0;
      port_r      <= '0;
      tok_r.valid <= 1'b0;
    end else begin
      key_r       <= key_nxt;
      ip_r        <= ip_nxt;
      port_r      <= port_nxt;
      tok_r.valid <= tok_nxt.valid;
    end
    tok_r.done <= tok_nxt.done;
    tok_r.ip   <= tok_nxt.ip;
    tok_r.port <= tok_nxt.port;
    slot_r     <= slot_nxt;
  end

  assign tok_out  = tok_r;
  assign slot_out = slot_r;
endmodule
`default_nettype wire
